@@ hw/rtl/ids_pkg.sv @@
// Shared types, constants and character-class helpers for the include directive scanner.
`timescale 1ns / 1ps

package ids_pkg;

  // Byte position counter width; the reported offset is always HASH_BITS wide.
  localparam int OFFSET_BITS = 24;
  localparam int HASH_BITS   = 24;
  localparam int TDATA_BITS  = 32;
  localparam int TUSER_BITS  = 3;

  // Characters the lexer and matcher look for.
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    logic                 path_byte_valid;
    logic [7:0]           path_char;
    logic                 directive_done;
    logic                 was_quoted;
    logic [HASH_BITS-1:0] hash_offset;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  // Letters of the keyword "include", by position.
  function automatic logic [7:0] word_letter(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h6E; // n
      3'd2:    ch = 8'h63; // c
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h75; // u
      3'd5:    ch = 8'h64; // d
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/ids_core.sv @@
// Lexer state, directive matcher and result generation for one byte per cycle while accept is high.
`timescale 1ns / 1ps

module ids_core
  import ids_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] code_byte,
  input  logic       final_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_CHR   = 3'd4
  } mode_t;

  // PH_L1..PH_L6 expect the keyword letter at index (phase - 2).
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_WS1     = 4'd1,
    PH_L1      = 4'd3,
    PH_L2      = 4'd4,
    PH_L3      = 4'd5,
    PH_L4      = 4'd6,
    PH_L5      = 4'd7,
    PH_L6      = 4'd8,
    PH_CHECK   = 4'd9,
    PH_WS2     = 4'd10,
    PH_PATH    = 4'd11,
    PH_PATHESC = 4'd12
  } phase_t;

  mode_t                  mode_r, mode_nxt;
  logic                   slash_r, slash_nxt;
  logic                   star_r, star_nxt;
  logic                   esc_r, esc_nxt;
  logic                   blank_r, blank_nxt;
  phase_t                 ph_r, ph_nxt, ph_m;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic       pvalid, done_m, quoted_m, hash_seen, taken, newline;
  logic       fin_done, fin_quoted;
  logic [7:0] close_ch;

  assign newline = (code_byte == CH_LF) || (code_byte == CH_CR);

  // Directive matcher.
  always_comb begin
    ph_m     = ph_r;
    pvalid   = 1'b0;
    done_m   = 1'b0;
    quoted_m = 1'b0;
    unique case (ph_r)
      PH_WS1: begin
        if (!is_ws(code_byte)) begin
          ph_m = (code_byte == word_letter(3'd0)) ? PH_L1 : PH_IDLE;
        end
      end
      PH_L1, PH_L2, PH_L3, PH_L4, PH_L5, PH_L6: begin
        ph_m = (code_byte == word_letter(3'(4'(ph_r) - 4'd2))) ?
               phase_t'(4'(ph_r) + 4'd1) : PH_IDLE;
      end
      PH_CHECK, PH_WS2: begin
        if (ph_r == PH_CHECK && is_ident(code_byte)) begin
          ph_m = PH_IDLE;
        end else if (is_ws(code_byte)) begin
          ph_m = PH_WS2;
        end else if (code_byte == CH_DQUOTE) begin
          ph_m = PH_PATH;
        end else begin
          done_m = 1'b1;
          ph_m   = PH_IDLE;
        end
      end
      PH_PATH: begin
        if (code_byte == CH_DQUOTE) begin
          done_m   = 1'b1;
          quoted_m = 1'b1;
          ph_m     = PH_IDLE;
        end else if (code_byte == CH_BSLASH && !final_byte) begin
          ph_m = PH_PATHESC;
        end else begin
          pvalid = 1'b1;
        end
      end
      PH_PATHESC: begin
        pvalid = 1'b1;
        ph_m   = PH_PATH;
      end
      default: ph_m = PH_IDLE;
    endcase
  end

  // Lexer.
  always_comb begin
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    esc_nxt   = esc_r;
    hash_seen = 1'b0;
    taken     = 1'b0;
    close_ch  = (mode_r == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
    unique case (mode_r)
      MODE_LINE: begin
        if (newline) mode_nxt = MODE_CODE;
      end
      MODE_BLOCK: begin
        if (star_r && code_byte == CH_SLASH) begin
          mode_nxt = MODE_CODE;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (code_byte == CH_STAR);
        end
      end
      MODE_STR, MODE_CHR: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (code_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (code_byte == close_ch) begin
          mode_nxt = MODE_CODE;
        end
      end
      default: begin
        mode_nxt = MODE_CODE;
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (code_byte == CH_SLASH) begin
            mode_nxt = MODE_LINE;
            taken    = 1'b1;
          end else if (code_byte == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
            taken    = 1'b1;
          end
        end
        if (!taken) begin
          if (code_byte == CH_SLASH) begin
            slash_nxt = 1'b1;
          end else if (code_byte == CH_DQUOTE) begin
            mode_nxt = MODE_STR;
            esc_nxt  = 1'b0;
          end else if (code_byte == CH_SQUOTE) begin
            mode_nxt = MODE_CHR;
            esc_nxt  = 1'b0;
          end else if (code_byte == CH_HASH && blank_r) begin
            hash_seen = 1'b1;
          end
        end
      end
    endcase
  end

  // Directive start, line-start tracking, position and end-of-text close.
  always_comb begin
    ph_nxt    = ph_m;
    start_nxt = start_r;
    if (hash_seen && ph_m == PH_IDLE) begin
      ph_nxt    = PH_WS1;
      start_nxt = pos_r;
    end
    blank_nxt = blank_r;
    if (newline) begin
      blank_nxt = 1'b1;
    end else if (!is_ws(code_byte)) begin
      blank_nxt = 1'b0;
    end
    pos_nxt = (pos_r != '1) ? pos_r + 1'b1 : pos_r;
    fin_done   = final_byte && (ph_nxt == PH_CHECK || ph_nxt == PH_WS2 ||
                                ph_nxt == PH_PATH || ph_nxt == PH_PATHESC);
    fin_quoted = final_byte && (ph_nxt == PH_PATH || ph_nxt == PH_PATHESC);
  end

  always_comb begin
    res_valid           = pvalid || done_m || fin_done;
    res.path_byte_valid = pvalid;
    res.path_char       = pvalid ? code_byte : 8'd0;
    res.directive_done  = done_m || fin_done;
    res.was_quoted      = quoted_m || fin_quoted;
    res.hash_offset     = (done_m || fin_done) ? HASH_BITS'(start_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && final_byte)) begin
      mode_r  <= MODE_CODE;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      esc_r   <= 1'b0;
      blank_r <= 1'b1;
      ph_r    <= PH_IDLE;
      start_r <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
      esc_r   <= esc_nxt;
      blank_r <= blank_nxt;
      ph_r    <= ph_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

@@ hw/rtl/ids_skid.sv @@
// Output register with a skid stage so the input side keeps flowing under back-pressure while the skid stage is empty.
`timescale 1ns / 1ps

module ids_skid
  import ids_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_res,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push && out_valid_r && !pop) begin
      skid_r       <= push_res;
      skid_valid_r <= 1'b1;
    end else if (push) begin
      out_r       <= push_res;
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/include_directive_scanner.sv @@
// Top level of the comment-aware include directive scanner.
// Results are registered in the output register, or the skid entry if the output stalls.
// Throughput: one byte per cycle while in_tready is high; lexer and matcher update in one
//   pass per byte; the output register and one skid entry absorb a single stalled result.
// Reset: rst_n low (synchronous) returns the scanner to plain code at offset zero and
//   empties the output stages; the byte marked by in_tlast resets the scanner the same way.
`timescale 1ns / 1ps

module include_directive_scanner
  import ids_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input requests: one source byte each.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,  // [7:0] code_byte
  input  logic                  in_tlast,  // final_byte
  // Result requests.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_BITS-1:0] out_tdata, // [7:0] path_char, [31:8] hash_offset
  output logic [TUSER_BITS-1:0] out_tuser  // [0] path_byte_valid, [1] directive_done,
                                           // [2] was_quoted
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // A request is taken whenever the skid stage is free; the scanner state
  // advances on that same edge.
  assign accept = in_tvalid && in_tready;

  ids_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .code_byte  (in_tdata),
    .final_byte (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Push only bytes that produce a result; the rest update state and vanish.
  ids_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_res  (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result from the lowest bit up.
  assign out_tdata = {out_res.hash_offset, out_res.path_char};
  assign out_tuser = {out_res.was_quoted, out_res.directive_done, out_res.path_byte_valid};

endmodule

@@ hw/rtl/ids_checker.sv @@
// Port-level checker for the include directive scanner, bound to the top level.
`timescale 1ns / 1ps

module ids_checker
  import ids_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_BITS-1:0] out_tdata,
  input logic [TUSER_BITS-1:0] out_tuser
);

  // Every result carries a path byte, a finished directive, or both.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || out_tuser[1]))
    else $error("result with neither path byte nor directive end");

  // A quoted flag only comes with a finished directive, and no offset without one.
  a_quoted_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (!out_tuser[2] && out_tdata[31:8] == '0))
    else $error("quoted flag or offset without directive end");

  // A result without a path byte carries a zero path character.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[7:0] == 8'd0))
    else $error("path character set without path byte");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind include_directive_scanner ids_checker u_ids_checker (.*);
